FILE: rtl/sqs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sqs_pkg
// shared constants, command codes and state encoding for the quantile summary
// ---------------------------------------------------------------------------
package sqs_pkg;

  localparam int unsigned MaxTuplesDefault  = 256;
  localparam int unsigned SampleBitsDefault = 32;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned QuantW   = 17;
  localparam int unsigned CountW   = 32;
  localparam int unsigned GapW     = 32;
  localparam int unsigned EpsW     = 24;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;

  localparam logic [EpsW-1:0]    EpsReset    = 24'd335544;
  localparam logic [PeriodW-1:0] PeriodReset = 16'd50;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TWO_EPS = 1'b0,
    REG_PERIOD  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_MRG_START,
    ST_MRG_TOP,
    ST_MRG_CUR,
    ST_MRG_EVAL,
    ST_MRG_NEXT,
    ST_MRG_LAST,
    ST_MRG_CPRD,
    ST_MRG_CPWR,
    ST_QRY_RD,
    ST_QRY_CHK,
    ST_DONE
  } state_t;

endpackage : sqs_pkg
`default_nettype wire

FILE: rtl/sqs_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sqs_ram
// generic single-port synchronous ram with registered read data
// ---------------------------------------------------------------------------
module sqs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : sqs_ram
`default_nettype wire

FILE: rtl/streaming_quantile_summary.sv
`default_nettype none
// ---------------------------------------------------------------------------
// streaming_quantile_summary
// sorted tuple summary (value, gap, slack) with insert, merge, query, clear
// ---------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in_     | in        | in_valid/in_ready   | cmd, sample, quantile
// out_    | out       | out_valid/out_ready | answer_value .. store_full
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// one command at a time through a sequencer around one tuple ram.
// insert: scans for the insert position, shifts the tuples above it up by one
// and writes the new tuple. merge: folds tuples from the top down, then
// packs the kept tuples back down to address 0.
// query: walks tuples upward. clear, nop, rejected insert go straight to done.
// reset needs no clearing pass; result register holds while out_ready is low.
// ---------------------------------------------------------------------------
module streaming_quantile_summary #(
  parameter int unsigned MaxTuples  = sqs_pkg::MaxTuplesDefault,
  parameter int unsigned SampleBits = sqs_pkg::SampleBitsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sqs_pkg::CmdW-1:0]      in_cmd,
  input  wire logic signed [SampleBits-1:0]  in_sample,
  input  wire logic [sqs_pkg::QuantW-1:0]    in_quantile,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SampleBits-1:0]       out_answer_value,
  output logic [sqs_pkg::CountW-1:0]         out_sample_count,
  output logic [$clog2(MaxTuples):0]         out_tuples_held,
  output logic                               out_was_empty,
  output logic                               out_store_full,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sqs_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [sqs_pkg::CfgDataW-1:0]  cfg_wdata
);
  import sqs_pkg::*;

  localparam int unsigned AW = $clog2(MaxTuples);
  localparam int unsigned OW = AW + 1;
  localparam int unsigned EW = SampleBits + GapW + GapW;

  state_t state_r, state_nxt;

  logic [EpsW-1:0]       eps_r;
  logic [PeriodW-1:0]    period_r;
  logic [CountW-1:0]     seen_r, seen_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;
  logic [PeriodW-1:0]    since_r, since_nxt;
  logic [CmdW-1:0]       cmd_r, cmd_nxt;
  logic signed [SampleBits-1:0] samp_r, samp_nxt;
  logic [QuantW-1:0]     quant_r, quant_nxt;

  // ptr = scan/read index, ii = insert shift index, wp = merge write index
  logic [OW-1:0]         ptr_r, ptr_nxt;
  logic [OW-1:0]         ii_r, ii_nxt;
  logic [OW-1:0]         wp_r, wp_nxt;
  logic [GapW+1:0]       run_r, run_nxt;
  logic [GapW-1:0]       gacc_r, gacc_nxt;
  logic [GapW-1:0]       upslk_r, upslk_nxt;
  logic [EW-1:0]         cur_r, cur_nxt;
  logic [63:0]           acc_r, acc_nxt;
  logic [GapW-1:0]       lim_r, lim_nxt;
  logic [CountW+1:0]     rank_r, rank_nxt;
  logic [EW-1:0]         hold_r, hold_nxt;
  logic [1:0]            ph_r, ph_nxt;

  logic signed [SampleBits-1:0] ans_r, ans_nxt;
  logic                  empty_r, empty_nxt, full_r, full_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic                  we;
  logic [AW-1:0]         addr;
  logic [EW-1:0]         wdata, rdata;
  logic signed [SampleBits-1:0] rd_val;
  logic [GapW-1:0]       rd_gap, rd_slk;

  assign rd_val = rdata[EW-1 -: SampleBits];
  assign rd_gap = rdata[2*GapW-1 -: GapW];
  assign rd_slk = rdata[GapW-1:0];

  sqs_ram #(.Width(EW), .Depth(MaxTuples)) u_tuples (
    .clk  (clk),
    .we   (we),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  // scaled bound and query target: products registered before use
  logic [EpsW+CountW-1:0]   prod;
  logic [QuantW+CountW-1:0] qprod;
  assign prod  = eps_r * seen_r;
  assign qprod = quant_r * seen_r;

  assign cfg_ready = (state_r == ST_IDLE) && !ovalid_r;
  assign in_ready  = (state_r == ST_IDLE) && !ovalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r    <= EpsReset;
      period_r <= PeriodReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TWO_EPS: eps_r    <= cfg_wdata[EpsW-1:0];
        REG_PERIOD:  period_r <= cfg_wdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      seen_r   <= '0;
      occ_r    <= '0;
      since_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seen_r   <= seen_nxt;
      occ_r    <= occ_nxt;
      since_r  <= since_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    samp_r  <= samp_nxt;
    quant_r <= quant_nxt;
    ptr_r   <= ptr_nxt;
    ii_r    <= ii_nxt;
    wp_r    <= wp_nxt;
    run_r   <= run_nxt;
    gacc_r  <= gacc_nxt;
    upslk_r <= upslk_nxt;
    cur_r   <= cur_nxt;
    acc_r   <= acc_nxt;
    lim_r   <= lim_nxt;
    rank_r  <= rank_nxt;
    hold_r  <= hold_nxt;
    ph_r    <= ph_nxt;
    ans_r   <= ans_nxt;
    empty_r <= empty_nxt;
    full_r  <= full_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    seen_nxt   = seen_r;
    occ_nxt    = occ_r;
    since_nxt  = since_r;
    ovalid_nxt = ovalid_r;
    cmd_nxt    = cmd_r;
    samp_nxt   = samp_r;
    quant_nxt  = quant_r;
    ptr_nxt    = ptr_r;
    ii_nxt     = ii_r;
    wp_nxt     = wp_r;
    run_nxt    = run_r;
    gacc_nxt   = gacc_r;
    upslk_nxt  = upslk_r;
    cur_nxt    = cur_r;
    acc_nxt    = acc_r;
    lim_nxt    = lim_r;
    rank_nxt   = rank_r;
    hold_nxt   = hold_r;
    ph_nxt     = ph_r;
    ans_nxt    = ans_r;
    empty_nxt  = empty_r;
    full_nxt   = full_r;
    we         = 1'b0;
    addr       = ptr_r[AW-1:0];
    wdata      = hold_r;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt   = in_cmd;
          samp_nxt  = in_sample;
          quant_nxt = in_quantile;
          ans_nxt   = '0;
          empty_nxt = 1'b0;
          full_nxt  = 1'b0;
          ptr_nxt   = '0;
          rank_nxt  = '0;
          unique case (cmd_t'(in_cmd))
            CMD_INSERT: begin
              if (occ_r == OW'(MaxTuples) || seen_r == '1) begin
                full_nxt  = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                seen_nxt  = seen_r + 1'b1;
                state_nxt = ST_INS_RD;
              end
            end
            CMD_QUERY: begin
              if (occ_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_QRY_RD;
              end
            end
            CMD_CLEAR: begin
              occ_nxt   = '0;
              seen_nxt  = '0;
              since_nxt = '0;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // find insert position: first entry whose value exceeds the sample
      ST_INS_RD: begin
        acc_nxt = 64'(prod);
        if (ptr_r == occ_r) begin
          state_nxt = ST_INS_SHIFT;
          ii_nxt    = occ_r;
        end else begin
          addr      = ptr_r[AW-1:0];
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (rd_val <= samp_r) begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = ST_INS_RD;
        end else begin
          ii_nxt    = occ_r;
          ph_nxt    = 2'd0;
          state_nxt = ST_INS_SHIFT;
        end
      end
      // move entries [ptr, occ) up by one, top first: read ii-1, write ii
      ST_INS_SHIFT: begin
        lim_nxt = acc_r[EpsW +: GapW];
        if (ii_r == ptr_r) begin
          state_nxt = ST_INS_PUT;
        end else begin
          unique case (ph_r)
            2'd0: begin
              addr   = AW'(ii_r - 1'b1);
              ph_nxt = 2'd1;
            end
            2'd1: begin
              hold_nxt = rdata;
              ph_nxt   = 2'd2;
            end
            default: begin
              we     = 1'b1;
              addr   = ii_r[AW-1:0];
              wdata  = hold_r;
              ii_nxt = ii_r - 1'b1;
              ph_nxt = 2'd0;
            end
          endcase
        end
      end
      ST_INS_PUT: begin
        we        = 1'b1;
        addr      = ptr_r[AW-1:0];
        wdata     = {samp_r, GapW'(1), lim_r};
        occ_nxt   = occ_r + 1'b1;
        since_nxt = since_r + 1'b1;
        if (since_r + 1'b1 >= period_r) begin
          since_nxt = '0;
          state_nxt = ST_MRG_START;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      // backward merge: kept tuples are packed downward from the top entry,
      // then copied back to start at address 0
      ST_MRG_START: begin
        if (occ_r < OW'(3)) begin
          state_nxt = ST_DONE;
        end else begin
          addr      = AW'(occ_r - 1'b1);
          ptr_nxt   = occ_r - OW'(2);
          wp_nxt    = occ_r - OW'(2);
          state_nxt = ST_MRG_TOP;
        end
      end
      // top entry stays in place, only its slack is needed
      ST_MRG_TOP: begin
        upslk_nxt = rd_slk;
        addr      = ptr_r[AW-1:0];
        state_nxt = ST_MRG_CUR;
      end
      ST_MRG_CUR: begin
        cur_nxt   = rdata;
        gacc_nxt  = rd_gap;
        run_nxt   = (GapW+2)'(rd_gap);
        addr      = AW'(ptr_r - 1'b1);
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = ST_MRG_EVAL;
      end
      // rdata holds the candidate below the current tuple
      ST_MRG_EVAL: begin
        if (run_r + (GapW+2)'(rd_gap) + (GapW+2)'(upslk_r) > (GapW+2)'(lim_r)) begin
          we        = 1'b1;
          addr      = wp_r[AW-1:0];
          wdata     = {cur_r[EW-1 -: SampleBits], gacc_r, cur_r[GapW-1:0]};
          wp_nxt    = wp_r - 1'b1;
          upslk_nxt = cur_r[GapW-1:0];
          cur_nxt   = rdata;
          gacc_nxt  = rd_gap;
          run_nxt   = (GapW+2)'(rd_gap);
          state_nxt = (ptr_r == '0) ? ST_MRG_LAST : ST_MRG_NEXT;
        end else begin
          gacc_nxt = gacc_r + rd_gap;
          run_nxt  = run_r + (GapW+2)'(rd_gap);
          if (ptr_r == '0) begin
            state_nxt = ST_MRG_LAST;
          end else begin
            addr    = AW'(ptr_r - 1'b1);
            ptr_nxt = ptr_r - 1'b1;
          end
        end
      end
      ST_MRG_NEXT: begin
        addr      = AW'(ptr_r - 1'b1);
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = ST_MRG_EVAL;
      end
      // kept tuples now sit in [wp, occ)
      ST_MRG_LAST: begin
        we    = 1'b1;
        addr  = wp_r[AW-1:0];
        wdata = {cur_r[EW-1 -: SampleBits], gacc_r, cur_r[GapW-1:0]};
        if (wp_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          occ_nxt   = occ_r - wp_r;
          ptr_nxt   = '0;
          state_nxt = ST_MRG_CPRD;
        end
      end
      ST_MRG_CPRD: begin
        if (ptr_r == occ_r) begin
          state_nxt = ST_DONE;
        end else begin
          addr      = AW'(wp_r + ptr_r);
          state_nxt = ST_MRG_CPWR;
        end
      end
      ST_MRG_CPWR: begin
        we        = 1'b1;
        addr      = ptr_r[AW-1:0];
        wdata     = rdata;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = ST_MRG_CPRD;
      end

      ST_QRY_RD: begin
        acc_nxt   = 64'(qprod);
        addr      = ptr_r[AW-1:0];
        state_nxt = ST_QRY_CHK;
      end
      ST_QRY_CHK: begin
        if (rank_r + (CountW+2)'(rd_gap) + (CountW+2)'(rd_slk) >=
            (CountW+2)'(acc_r[63:16])) begin
          ans_nxt   = rd_val;
          state_nxt = ST_DONE;
        end else if (ptr_r + 1'b1 == occ_r) begin
          ans_nxt   = rd_val;
          state_nxt = ST_DONE;
        end else begin
          rank_nxt  = rank_r + (CountW+2)'(rd_gap);
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = ST_QRY_RD;
        end
      end

      ST_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid        = ovalid_r;
  assign out_answer_value = ans_r;
  assign out_sample_count = seen_r;
  assign out_tuples_held  = occ_r;
  assign out_was_empty    = empty_r;
  assign out_store_full   = full_r;

endmodule : streaming_quantile_summary
`default_nettype wire

FILE: sim/streaming_quantile_summary_tb.sv
// ---------------------------------------------------------------------------
// streaming_quantile_summary_tb
// self-checking bench: a behavioral summary model predicts every result beat,
// and a monitor compares each accepted result field by field, in order
// ---------------------------------------------------------------------------
module streaming_quantile_summary_tb;
  import sqs_pkg::*;

  localparam int unsigned Tuples    = 256;
  localparam int unsigned CycleCap  = 10000000;
  localparam int unsigned DrainWait = 20;

  typedef struct {
    logic signed [31:0] answer;
    logic [31:0]        count;
    logic [8:0]         held;
    logic               empty;
    logic               full;
  } summary_beat_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CmdW-1:0]     in_cmd;
  logic signed [31:0]  in_sample;
  logic [QuantW-1:0]   in_quantile;
  logic                out_valid;
  logic                out_ready;
  logic signed [31:0]  out_answer_value;
  logic [CountW-1:0]   out_sample_count;
  logic [8:0]          out_tuples_held;
  logic                out_was_empty;
  logic                out_store_full;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  // summary model state
  logic signed [31:0] mdl_value [Tuples];
  logic [63:0]        mdl_gap   [Tuples];
  logic [63:0]        mdl_slack [Tuples];
  logic [31:0]        mdl_seen;
  int unsigned        mdl_occ;
  logic [15:0]        mdl_since;
  logic [23:0]        mdl_two_eps;
  logic [15:0]        mdl_period;

  summary_beat_t pending_beats[$];
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   recv_hold;
  int unsigned   cycle_count;
  bit            failed;

  streaming_quantile_summary i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_sample        (in_sample),
    .in_quantile      (in_quantile),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_answer_value (out_answer_value),
    .out_sample_count (out_sample_count),
    .out_tuples_held  (out_tuples_held),
    .out_was_empty    (out_was_empty),
    .out_store_full   (out_store_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rank_bound();
    return (64'(mdl_two_eps) * 64'(mdl_seen)) >> 24;
  endfunction

  function automatic void drop_tuple(int k);
    for (int m = k; m + 1 < mdl_occ; m++) begin
      mdl_value[m] = mdl_value[m + 1];
      mdl_gap[m]   = mdl_gap[m + 1];
      mdl_slack[m] = mdl_slack[m + 1];
    end
    mdl_occ--;
  endfunction

  // backward pass folding neighbors while gap sum plus next slack stays in bound
  function automatic void merge_tuples();
    logic [63:0] limit;
    logic [63:0] run;
    int i;
    int j;
    if (mdl_occ < 3) return;
    limit = rank_bound();
    i = int'(mdl_occ) - 2;
    while (i > 0) begin
      run = mdl_gap[i];
      j = i - 1;
      while (j >= 0) begin
        run += mdl_gap[j];
        if (run + mdl_slack[i + 1] > limit) break;
        mdl_gap[i] = (mdl_gap[i] + mdl_gap[j]) & 64'hFFFF_FFFF;
        drop_tuple(j);
        i--;
        j--;
      end
      i--;
    end
  endfunction

  function automatic void predict_summary(cmd_t c, logic signed [31:0] s, logic [16:0] q);
    summary_beat_t b;
    int pos;
    logic [63:0] target;
    logic [63:0] rank;
    bit hit;
    b = '{answer: '0, count: '0, held: '0, empty: 1'b0, full: 1'b0};
    case (c)
      CMD_INSERT: begin
        if (mdl_occ >= Tuples || mdl_seen == 32'hFFFF_FFFF) begin
          b.full = 1'b1;
        end else begin
          mdl_seen++;
          pos = 0;
          while (pos < mdl_occ && mdl_value[pos] <= s) pos++;
          for (int m = mdl_occ; m > pos; m--) begin
            mdl_value[m] = mdl_value[m - 1];
            mdl_gap[m]   = mdl_gap[m - 1];
            mdl_slack[m] = mdl_slack[m - 1];
          end
          mdl_value[pos] = s;
          mdl_gap[pos]   = 64'd1;
          mdl_slack[pos] = rank_bound() & 64'hFFFF_FFFF;
          mdl_occ++;
          mdl_since++;
          if (mdl_since >= mdl_period) begin
            merge_tuples();
            mdl_since = '0;
          end
        end
      end
      CMD_QUERY: begin
        if (mdl_occ == 0) begin
          b.empty = 1'b1;
        end else begin
          target = (64'(q) * 64'(mdl_seen)) >> 16;
          rank = '0;
          hit = 1'b0;
          for (int k = 0; k < mdl_occ && !hit; k++) begin
            rank += mdl_gap[k];
            if (rank + mdl_slack[k] >= target) begin
              b.answer = mdl_value[k];
              hit = 1'b1;
            end
          end
          if (!hit) b.answer = mdl_value[mdl_occ - 1];
        end
      end
      CMD_CLEAR: begin
        mdl_occ = 0;
        mdl_seen = '0;
        mdl_since = '0;
      end
      default: ;
    endcase
    b.count = mdl_seen;
    b.held  = 9'(mdl_occ);
    pending_beats.push_back(b);
  endfunction

  // one command beat; valid stays high into the next call unless a gap is drawn
  task automatic send_cmd(cmd_t c, logic signed [31:0] s = '0, logic [16:0] q = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_cmd      = c;
    in_sample   = s;
    in_quantile = q;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_summary(c, s, q);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] data);
    wait_drained();
    cfg_index = idx;
    cfg_wdata = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TWO_EPS) mdl_two_eps = data;
    else mdl_period = data[15:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(0, 7) - 4;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  function automatic logic [16:0] pick_quantile();
    case ($urandom_range(5))
      0:       return 17'($urandom());
      1:       return 17'd65536;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic test_directed();
    send_cmd(CMD_QUERY, '0, 17'd32768);          // empty summary
    send_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'sh8000_0000);
    send_cmd(CMD_INSERT, 32'sd0);
    send_cmd(CMD_INSERT, 32'sd0);                // duplicate goes after equal
    send_cmd(CMD_INSERT, -32'sd1);
    send_cmd(CMD_INSERT, 32'sh5555_5555);
    send_cmd(CMD_INSERT, 32'shAAAA_AAAA);
    send_cmd(CMD_QUERY, '0, 17'd0);
    send_cmd(CMD_QUERY, '0, 17'd65536);
    send_cmd(CMD_QUERY, '0, 17'h1FFFF);          // above one
    send_cmd(CMD_QUERY, '0, 17'h0AAAA);
    send_cmd(CMD_QUERY, '0, 17'h15555);
    send_cmd(CMD_NOP, 32'shFFFF_FFFF, 17'h1FFFF);
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_QUERY, '0, 17'd65536);
    send_cmd(CMD_INSERT, 32'sd42);
    send_cmd(CMD_QUERY, '0, 17'd16384);
    send_cmd(CMD_CLEAR);
  endtask

  task automatic test_store_full();
    write_reg(REG_TWO_EPS, 24'd0);
    write_reg(REG_PERIOD, 24'h00FFFF);
    send_cmd(CMD_CLEAR);
    for (int k = 0; k < Tuples + 2; k++) send_cmd(CMD_INSERT, k - 100);
    send_cmd(CMD_QUERY, '0, 17'd32768);
    send_cmd(CMD_QUERY, '0, 17'h1FFFF);
    send_cmd(CMD_CLEAR);
  endtask

  // receiver held off for a long stretch while commands keep coming
  task automatic test_backpressure();
    recv_hold = 3000;
    for (int k = 0; k < 12; k++) send_cmd(CMD_INSERT, pick_sample());
    send_cmd(CMD_QUERY, '0, pick_quantile());
  endtask

  task automatic test_random(int unsigned beats, int unsigned s_idle, int unsigned r_idle);
    int unsigned pick;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned k = 0; k < beats; k++) begin
      pick = $urandom_range(99);
      if (pick < 62) send_cmd(CMD_INSERT, pick_sample(), 17'($urandom()));
      else if (pick < 92) send_cmd(CMD_QUERY, 32'($urandom()), pick_quantile());
      else if (pick < 96) send_cmd(CMD_CLEAR, 32'($urandom()), 17'($urandom()));
      else send_cmd(CMD_NOP, 32'($urandom()), 17'($urandom()));
    end
  endtask

  // receiver side: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (recv_hold != 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    summary_beat_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("streaming_quantile_summary regression: fail");
      $finish;
    end else if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no command outstanding");
        failed = 1'b1;
      end else begin
        e = pending_beats.pop_front();
        if (out_answer_value !== e.answer) begin
          $error("answer_value exp %0d got %0d", e.answer, out_answer_value);
          failed = 1'b1;
        end
        if (out_sample_count !== e.count) begin
          $error("sample_count exp %0d got %0d", e.count, out_sample_count);
          failed = 1'b1;
        end
        if (out_tuples_held !== e.held) begin
          $error("tuples_held exp %0d got %0d", e.held, out_tuples_held);
          failed = 1'b1;
        end
        if (out_was_empty !== e.empty) begin
          $error("was_empty exp %0b got %0b", e.empty, out_was_empty);
          failed = 1'b1;
        end
        if (out_store_full !== e.full) begin
          $error("store_full exp %0b got %0b", e.full, out_store_full);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_NOP;
    in_sample = '0;
    in_quantile = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_TWO_EPS;
    cfg_wdata = '0;
    recv_hold = 0;
    cycle_count = 0;
    failed = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mdl_occ = 0;
    mdl_seen = '0;
    mdl_since = '0;
    mdl_two_eps = EpsReset;
    mdl_period = PeriodReset;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_directed();
    test_store_full();
    write_reg(REG_TWO_EPS, 24'd335544);
    write_reg(REG_PERIOD, 24'd50);
    test_backpressure();

    write_reg(REG_PERIOD, 24'd0);               // merge on every insert
    write_reg(REG_TWO_EPS, 24'hFFFFFF);
    test_random(160, 34, 65);
    write_reg(REG_TWO_EPS, 24'd1);
    write_reg(REG_PERIOD, 24'd1);
    test_random(160, 65, 34);
    write_reg(REG_TWO_EPS, 24'd1677721);
    write_reg(REG_PERIOD, 24'd7);
    test_random(160, 0, 0);

    wait_drained();
    if (!failed) begin
      $display("streaming_quantile_summary regression: pass");
    end else begin
      $display("streaming_quantile_summary regression: fail");
    end
    $finish;
  end

endmodule
